/* src/srl_pkg.sv */
// Shared types and codes for the S-record stream loader.
`default_nettype none

package srl_pkg;

  localparam int unsigned AddrW = 33;

  // Parser phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_TYPE  = 3'd1;
  localparam logic [2:0] PH_COUNT = 3'd2;
  localparam logic [2:0] PH_ADDR  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CSUM  = 3'd5;
  localparam logic [2:0] PH_TRAIL = 3'd6;
  localparam logic [2:0] PH_SKIP  = 3'd7;

  // Result kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef struct packed {
    logic [2:0]       phase;
    logic [1:0]       rec_type;
    logic [3:0]       digit_cnt;
    logic [7:0]       bytes_left;
    logic [AddrW-1:0] addr;
    logic [7:0]       csum;
    logic [3:0]       hi_nib;
    logic             high_addr_seen;
    logic             err_latched;
  } srl_state_t;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] address;
    logic [7:0]       data_byte;
    logic [1:0]       status;
    logic             large_model;
  } srl_result_t;

endpackage

`default_nettype wire

/* src/srl_step.sv */
// Next-state and result logic for one character of the S-record parser.
`default_nettype none

module srl_step (
  input  var srl_pkg::srl_state_t  state_i,
  input  wire logic [7:0]          char_i,
  input  wire logic                eof_i,
  input  wire logic                word_mode_i,
  output var srl_pkg::srl_state_t  state_o,
  output wire logic                emit_o,
  output var srl_pkg::srl_result_t result_o
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
    end else begin
      t = 8'h00;
    end
    return t[3:0];
  endfunction

  srl_pkg::srl_state_t nxt;
  logic [3:0]                 nib;
  logic [7:0]                 byte_val;
  logic [2:0]                 min_cnt;
  logic [3:0]                 cnt_inc;
  logic [3:0]                 addr_digits;
  logic [srl_pkg::AddrW-1:0]  addr_sh;
  logic [1:0]                 err;
  logic                       wr;
  logic                       emit;
  logic                       line_done;

  assign nib         = hex_val(char_i);
  assign byte_val    = {state_i.hi_nib, nib};
  assign min_cnt     = {1'b0, state_i.rec_type} + 3'd2;
  assign cnt_inc     = state_i.digit_cnt + 4'd1;
  assign addr_digits = {1'b0, state_i.rec_type, 1'b0} + 4'd2;
  assign addr_sh     = {state_i.addr[srl_pkg::AddrW-5:0], nib};

  always_comb begin
    nxt = state_i;
    err = srl_pkg::ST_OK;
    wr  = 1'b0;
    if (!state_i.err_latched) begin
      unique case (state_i.phase)
        srl_pkg::PH_START: begin
          if (char_i == CH_UP_S || char_i == CH_LO_S) begin
            nxt.phase = srl_pkg::PH_TYPE;
          end else if (char_i != CH_SPACE && char_i != CH_TAB && char_i != CH_CR) begin
            err = srl_pkg::ST_ILLEGAL;
          end
        end
        srl_pkg::PH_TYPE: begin
          if (char_i == CH_0 || (char_i >= CH_7 && char_i <= CH_9)) begin
            nxt.phase = srl_pkg::PH_SKIP;
          end else if (char_i >= CH_1 && char_i <= CH_3) begin
            nxt.rec_type  = char_i[1:0];
            nxt.digit_cnt = 4'd0;
            nxt.phase     = srl_pkg::PH_COUNT;
          end else begin
            err = srl_pkg::ST_ILLEGAL;
          end
        end
        srl_pkg::PH_COUNT, srl_pkg::PH_ADDR, srl_pkg::PH_DATA, srl_pkg::PH_CSUM: begin
          if (char_i == CH_LF) begin
            err = srl_pkg::ST_ILLEGAL;
          end else if (!state_i.digit_cnt[0]) begin
            // first digit of a byte: hold the high nibble
            nxt.hi_nib    = nib;
            nxt.digit_cnt = cnt_inc;
            if (state_i.phase == srl_pkg::PH_ADDR) begin
              nxt.addr = addr_sh;
            end
          end else begin
            nxt.digit_cnt = cnt_inc;
            unique case (state_i.phase)
              srl_pkg::PH_COUNT: begin
                if (byte_val < {5'd0, min_cnt}) begin
                  err = srl_pkg::ST_ILLEGAL;
                end else begin
                  nxt.csum       = byte_val;
                  nxt.bytes_left = byte_val - {5'd0, min_cnt};
                  nxt.addr       = '0;
                  nxt.digit_cnt  = 4'd0;
                  nxt.phase      = srl_pkg::PH_ADDR;
                end
              end
              srl_pkg::PH_ADDR: begin
                nxt.addr = addr_sh;
                nxt.csum = state_i.csum + byte_val;
                if (cnt_inc >= addr_digits) begin
                  if (word_mode_i) begin
                    nxt.addr = {addr_sh[srl_pkg::AddrW-2:0], 1'b0};
                  end
                  nxt.digit_cnt = 4'd0;
                  nxt.phase = (state_i.bytes_left != 8'd0) ? srl_pkg::PH_DATA
                                                           : srl_pkg::PH_CSUM;
                end
              end
              srl_pkg::PH_DATA: begin
                if (|state_i.addr[srl_pkg::AddrW-1:16]) begin
                  nxt.high_addr_seen = 1'b1;
                end
                wr             = 1'b1;
                nxt.csum       = state_i.csum + byte_val;
                nxt.addr       = state_i.addr + srl_pkg::AddrW'(1);
                nxt.bytes_left = state_i.bytes_left - 8'd1;
                nxt.digit_cnt  = 4'd0;
                if (state_i.bytes_left == 8'd1) begin
                  nxt.phase = srl_pkg::PH_CSUM;
                end
              end
              default: begin
                nxt.digit_cnt = 4'd0;
                if (~state_i.csum != byte_val) begin
                  err = srl_pkg::ST_CSUM;
                end else begin
                  nxt.phase = srl_pkg::PH_TRAIL;
                end
              end
            endcase
          end
        end
        default: begin
          if (char_i == CH_LF) begin
            nxt.phase = srl_pkg::PH_START;
          end
        end
      endcase
    end
    if (err != srl_pkg::ST_OK) begin
      nxt.err_latched = 1'b1;
    end
  end

  assign line_done = (nxt.phase == srl_pkg::PH_START) || (nxt.phase == srl_pkg::PH_TRAIL)
                     || (nxt.phase == srl_pkg::PH_SKIP);

  always_comb begin
    result_o.kind        = srl_pkg::KIND_STATUS;
    result_o.address     = '0;
    result_o.data_byte   = 8'd0;
    result_o.status      = err;
    result_o.large_model = nxt.high_addr_seen;
    emit                 = 1'b0;
    state_o              = nxt;
    if (err != srl_pkg::ST_OK) begin
      emit = 1'b1;
    end else if (eof_i) begin
      // drop any write from the final character; report end of load
      emit            = !state_i.err_latched;
      result_o.status = line_done ? srl_pkg::ST_OK : srl_pkg::ST_ILLEGAL;
    end else if (wr) begin
      emit               = 1'b1;
      result_o.kind      = srl_pkg::KIND_WRITE;
      result_o.address   = state_i.addr;
      result_o.data_byte = byte_val;
    end
    if (eof_i) begin
      state_o                = '0;
      state_o.phase          = srl_pkg::PH_START;
      state_o.high_addr_seen = nxt.high_addr_seen;
    end
  end

  assign emit_o = emit;

endmodule

`default_nettype wire

/* src/srecord_stream_loader.sv */
// Top level of the S-record stream loader: input stage, parser state and result stage.
`default_nettype none

// Takes S-record text one character per transfer and returns a byte write for every data
// byte of an S1, S2 or S3 line, and one status result when the file ends or at the first
// error. A new character is taken every cycle while the input register is free or moves on;
// a character passes through the input register, then the parser update writes its result
// into the result register, from which it is transferred. The input stage keeps taking
// characters while a result waits, as long as the one register in front of the parser
// is free or moves on. word_address_mode doubles each record address and may be
// changed only while no file is in flight.
module srecord_stream_loader (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output wire logic                      in_ready_o,
  input  wire logic [7:0]                char_code_i,
  input  wire logic                      end_of_file_i,
  output wire logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output wire logic                      kind_o,
  output wire logic [srl_pkg::AddrW-1:0] address_o,
  output wire logic [7:0]                data_byte_o,
  output wire logic [1:0]                status_o,
  output wire logic                      large_model_o
);

  logic                 word_mode_q;
  logic                 in_valid_q;
  logic [7:0]           char_q;
  logic                 eof_q;
  logic                 out_valid_q;
  logic                 fire;
  logic                 step_emit;
  srl_pkg::srl_state_t  state_q;
  srl_pkg::srl_state_t  state_d;
  srl_pkg::srl_result_t step_res;
  srl_pkg::srl_result_t res_q;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      word_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_code_i;
      eof_q  <= end_of_file_i;
    end
  end

  srl_step u_step (
    .state_i     (state_q),
    .char_i      (char_q),
    .eof_i       (eof_q),
    .word_mode_i (word_mode_q),
    .state_o     (state_d),
    .emit_o      (step_emit),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= '0;
      state_q.phase <= srl_pkg::PH_START;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= step_emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step_emit) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = res_q.kind;
  assign address_o     = res_q.address;
  assign data_byte_o   = res_q.data_byte;
  assign status_o      = res_q.status;
  assign large_model_o = res_q.large_model;

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !fire)
    else $error("result register overwritten while stalled");

  // the large-address flag only ever sets
  a_large_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.high_addr_seen |=> state_q.high_addr_seen)
    else $error("large flag cleared");

  // after an error nothing more comes out until the file ends
  a_latched_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && state_q.err_latched |-> !step_emit)
    else $error("result emitted after latched error");

  // byte writes always carry ok status
  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && step_emit && step_res.kind == srl_pkg::KIND_WRITE
    |=> out_valid_q && status_o == srl_pkg::ST_OK)
    else $error("write result with nonzero status");

endmodule

`default_nettype wire
